// ===== rtl/nsc_pkg.sv =====
// ---------------------------------------------------------------------------
// nsc_pkg
// Shared widths, character codes, verdict codes and the sentence code table
// of the NMEA line checker.
// ---------------------------------------------------------------------------
package nsc_pkg;

   localparam int CHAR_WIDTH    = 8;
   localparam int VERDICT_WIDTH = 3;
   localparam int KIND_WIDTH    = 4;
   localparam int LEN_WIDTH     = 8;
   localparam int CSR_IDX_WIDTH = 1;
   localparam int HEADER_DEPTH  = 5;
   localparam int KIND_COUNT    = 14;

   typedef logic [CHAR_WIDTH-1:0]    char_type;
   typedef logic [VERDICT_WIDTH-1:0] verdict_type;
   typedef logic [KIND_WIDTH-1:0]    kind_type;
   typedef logic [LEN_WIDTH-1:0]     len_type;
   typedef logic [CSR_IDX_WIDTH-1:0] csr_idx_type;

   localparam csr_idx_type CSR_MIN_LENGTH = 1'd0;
   localparam csr_idx_type CSR_MAX_LENGTH = 1'd1;

   localparam len_type MIN_LENGTH_RESET = 8'd10;
   localparam len_type MAX_LENGTH_RESET = 8'd180;
   localparam len_type LEN_MAX          = 8'd255;

   localparam char_type CHAR_STAR   = 8'h2a;
   localparam char_type CHAR_DOLLAR = 8'h24;
   localparam char_type CHAR_BANG   = 8'h21;

   localparam verdict_type VERDICT_OK_DOLLAR  = 3'd0;
   localparam verdict_type VERDICT_OK_BANG    = 3'd1;
   localparam verdict_type VERDICT_BAD_LENGTH = 3'd2;
   localparam verdict_type VERDICT_BAD_START  = 3'd3;
   localparam verdict_type VERDICT_NO_STAR    = 3'd4;
   localparam verdict_type VERDICT_MISMATCH   = 3'd5;
   localparam verdict_type VERDICT_UNKNOWN    = 3'd6;

   localparam kind_type KIND_UNKNOWN = 4'd0;

   // three-letter codes, kind k+1 at entry k
   localparam logic [3*CHAR_WIDTH-1:0] KIND_CODES [KIND_COUNT] = '{
      "MWV", "MWD", "VWR", "VWT", "MDA", "MTA", "RMB",
      "RMC", "VHW", "HDM", "XDR", "ROT", "RSA", "APB"
   };

   // bit 4 set when the character is a hex digit, low nibble its value
   function automatic logic [4:0] hex_digit(input char_type c);
      logic [4:0] result;
      result = 5'd0;
      if (c >= "0" && c <= "9") begin
         result = {1'b1, 4'(c - "0")};
      end else if (c >= "a" && c <= "f") begin
         result = {1'b1, 4'(c - "a" + 8'd10)};
      end else if (c >= "A" && c <= "F") begin
         result = {1'b1, 4'(c - "A" + 8'd10)};
      end
      return result;
   endfunction

endpackage

// ===== rtl/nsc_kind_decode.sv =====
// ---------------------------------------------------------------------------
// nsc_kind_decode
// Matches the three sentence code characters against the known codes and
// returns the sentence kind, zero when none matches.
// ---------------------------------------------------------------------------
module nsc_kind_decode (
   input  nsc_pkg::char_type code_first,
   input  nsc_pkg::char_type code_second,
   input  nsc_pkg::char_type code_third,
   output nsc_pkg::kind_type kind
);
   import nsc_pkg::*;

   logic [3*CHAR_WIDTH-1:0] code;

   assign code = {code_first, code_second, code_third};

   // codes are distinct, so at most one entry matches
   always_comb begin
      kind = KIND_UNKNOWN;
      for (int k = 0; k < KIND_COUNT; k++) begin
         if (code == KIND_CODES[k]) begin
            kind = KIND_WIDTH'(k + 1);
         end
      end
   end

endmodule

// ===== rtl/nmea_sentence_checker_unit.sv =====
// ---------------------------------------------------------------------------
// nmea_sentence_checker_unit
// Checks NMEA 0183 lines arriving one character per transaction: length,
// start character, checksum after the last star and sentence code.
// ---------------------------------------------------------------------------
// channel   direction  handshake           payload
// req       in         req_valid/req_stall char_code, line_end
// rsp       out        rsp_valid/rsp_stall verdict, kind, talker, sums, length
// csr       in         csr_valid/csr_ready register index, 8-bit data
//
// one character per cycle unless a stalled result holds a line end back; a verdict
// follows the last character of a line through the input, then result register
// reset clears the line state and loads min_length 10 and max_length 180
// only a line end needs the result register, so a stalled result holds back
// the input only when the next character closes another line
// ---------------------------------------------------------------------------
module nmea_sentence_checker_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  nsc_pkg::char_type     req_char_code,
   input  logic                  req_line_end,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output nsc_pkg::verdict_type  rsp_verdict,
   output nsc_pkg::kind_type     rsp_sentence_kind,
   output nsc_pkg::char_type     rsp_talker_first,
   output nsc_pkg::char_type     rsp_talker_second,
   output nsc_pkg::char_type     rsp_computed_sum,
   output nsc_pkg::char_type     rsp_received_sum,
   output logic                  rsp_received_too_big,
   output nsc_pkg::len_type      rsp_line_length,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  nsc_pkg::csr_idx_type  csr_index,
   input  nsc_pkg::char_type     csr_data
);
   import nsc_pkg::*;

   // configuration
   len_type min_length_ff, max_length_ff;

   // input register
   logic     in_valid_ff;
   char_type in_char_ff;
   logic     in_last_ff;
   logic     in_advance;
   logic     req_take;

   // line state
   len_type  position_ff, position_in;
   char_type running_xor_ff, running_xor_in;
   char_type xor_at_star_ff, xor_at_star_in;
   logic     star_seen_ff, star_seen_in;
   char_type hex_value_ff, hex_value_in;
   logic     hex_overflow_ff, hex_overflow_in;
   logic     hex_stopped_ff, hex_stopped_in;
   char_type start_char_ff, start_char_in;
   char_type header_ff [HEADER_DEPTH];
   char_type header_in [HEADER_DEPTH];

   // result
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_load;
   verdict_type verdict_in, verdict_ff;
   kind_type    kind_in, kind_ff;
   char_type    computed_in, computed_ff;
   char_type    received_in, received_ff;
   logic        too_big_in, too_big_ff;
   char_type    talker_first_ff, talker_second_ff;
   len_type     length_ff;
   logic [4:0]  digit;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MIN_LENGTH_RESET;
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_LENGTH: min_length_ff <= csr_data;
            CSR_MAX_LENGTH: max_length_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // a line end needs a free result slot, other characters move on at once
   assign in_advance = in_valid_ff && (!in_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !in_advance;
   assign req_take   = req_valid && !req_stall;
   assign rsp_load   = in_advance && in_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (in_advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_char_code;
         in_last_ff <= req_line_end;
      end
   end

   // state after this character
   always_comb begin
      digit           = hex_digit(in_char_ff);
      start_char_in   = start_char_ff;
      xor_at_star_in  = xor_at_star_ff;
      star_seen_in    = star_seen_ff;
      hex_value_in    = hex_value_ff;
      hex_overflow_in = hex_overflow_ff;
      hex_stopped_in  = hex_stopped_ff;
      running_xor_in  = running_xor_ff;
      for (int i = 0; i < HEADER_DEPTH; i++) begin
         header_in[i] = header_ff[i];
         if (position_ff == LEN_WIDTH'(i + 1)) begin
            header_in[i] = in_char_ff;
         end
      end
      if (position_ff == '0) begin
         start_char_in = in_char_ff;
      end else begin
         if (in_char_ff == CHAR_STAR) begin
            xor_at_star_in  = running_xor_ff;
            star_seen_in    = 1'b1;
            hex_value_in    = '0;
            hex_overflow_in = 1'b0;
            hex_stopped_in  = 1'b0;
         end else if (star_seen_ff && !hex_stopped_ff) begin
            if (!digit[4]) begin
               hex_stopped_in = 1'b1;
            end else begin
               if (hex_value_ff[7:4] != 4'd0) begin
                  hex_overflow_in = 1'b1;
               end
               hex_value_in = {hex_value_ff[3:0], digit[3:0]};
            end
         end
         running_xor_in = running_xor_ff ^ in_char_ff;
      end
      position_in = (position_ff == LEN_MAX) ? LEN_MAX : position_ff + 8'd1;
   end

   nsc_kind_decode u_kind (
      .code_first  (header_in[2]),
      .code_second (header_in[3]),
      .code_third  (header_in[4]),
      .kind        (kind_in)
   );

   always_comb begin
      computed_in = star_seen_in ? xor_at_star_in : '0;
      received_in = star_seen_in ? hex_value_in : '0;
      too_big_in  = star_seen_in && hex_overflow_in;
      if (position_in < min_length_ff || position_in > max_length_ff) begin
         verdict_in = VERDICT_BAD_LENGTH;
      end else if (start_char_in != CHAR_DOLLAR && start_char_in != CHAR_BANG) begin
         verdict_in = VERDICT_BAD_START;
      end else if (!star_seen_in) begin
         verdict_in = VERDICT_NO_STAR;
      end else if (too_big_in || received_in != computed_in) begin
         verdict_in = VERDICT_MISMATCH;
      end else if (start_char_in == CHAR_BANG) begin
         verdict_in = VERDICT_OK_BANG;
      end else if (kind_in == KIND_UNKNOWN) begin
         verdict_in = VERDICT_UNKNOWN;
      end else begin
         verdict_in = VERDICT_OK_DOLLAR;
      end
   end

   // line end clears the state for the next line
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff     <= '0;
         running_xor_ff  <= '0;
         xor_at_star_ff  <= '0;
         star_seen_ff    <= 1'b0;
         hex_value_ff    <= '0;
         hex_overflow_ff <= 1'b0;
         hex_stopped_ff  <= 1'b0;
         start_char_ff   <= '0;
         for (int i = 0; i < HEADER_DEPTH; i++) begin
            header_ff[i] <= '0;
         end
      end else if (in_advance) begin
         if (in_last_ff) begin
            position_ff     <= '0;
            running_xor_ff  <= '0;
            xor_at_star_ff  <= '0;
            star_seen_ff    <= 1'b0;
            hex_value_ff    <= '0;
            hex_overflow_ff <= 1'b0;
            hex_stopped_ff  <= 1'b0;
            start_char_ff   <= '0;
            for (int i = 0; i < HEADER_DEPTH; i++) begin
               header_ff[i] <= '0;
            end
         end else begin
            position_ff     <= position_in;
            running_xor_ff  <= running_xor_in;
            xor_at_star_ff  <= xor_at_star_in;
            star_seen_ff    <= star_seen_in;
            hex_value_ff    <= hex_value_in;
            hex_overflow_ff <= hex_overflow_in;
            hex_stopped_ff  <= hex_stopped_in;
            start_char_ff   <= start_char_in;
            for (int i = 0; i < HEADER_DEPTH; i++) begin
               header_ff[i] <= header_in[i];
            end
         end
      end
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         verdict_ff       <= verdict_in;
         kind_ff          <= kind_in;
         talker_first_ff  <= header_in[0];
         talker_second_ff <= header_in[1];
         computed_ff      <= computed_in;
         received_ff      <= received_in;
         too_big_ff       <= too_big_in;
         length_ff        <= position_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_verdict          = verdict_ff;
   assign rsp_sentence_kind    = kind_ff;
   assign rsp_talker_first     = talker_first_ff;
   assign rsp_talker_second    = talker_second_ff;
   assign rsp_computed_sum     = computed_ff;
   assign rsp_received_sum     = received_ff;
   assign rsp_received_too_big = too_big_ff;
   assign rsp_line_length      = length_ff;

endmodule

// ===== rtl/nsc_checker.sv =====
// ---------------------------------------------------------------------------
// nsc_checker
// Port-level checks on the result channel of the NMEA line checker, bound to
// the top level.
// ---------------------------------------------------------------------------
module nsc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input nsc_pkg::verdict_type rsp_verdict,
   input nsc_pkg::kind_type    rsp_sentence_kind,
   input nsc_pkg::char_type    rsp_computed_sum,
   input nsc_pkg::char_type    rsp_received_sum,
   input logic                 rsp_received_too_big
);
   import nsc_pkg::*;

   // nothing left over from before reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_verdict)
         && $stable(rsp_computed_sum) && $stable(rsp_received_sum))
      else $error("stalled result changed");

   // an accepted line always carries a matching checksum
   a_ok_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict == VERDICT_OK_DOLLAR || rsp_verdict == VERDICT_OK_BANG)
         |-> !rsp_received_too_big && rsp_computed_sum == rsp_received_sum)
      else $error("ok verdict with checksum mismatch");

   a_no_star_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == VERDICT_NO_STAR
         |-> rsp_computed_sum == '0 && rsp_received_sum == '0 && !rsp_received_too_big)
      else $error("checksum fields set without a star");

   a_ok_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == VERDICT_OK_DOLLAR |-> rsp_sentence_kind != KIND_UNKNOWN)
      else $error("ok dollar line with unknown sentence kind");

endmodule

bind nmea_sentence_checker_unit nsc_checker u_nsc_checker (.*);

// ===== test/nsc_line_checker.sv =====
// ---------------------------------------------------------------------------
// nsc_line_checker
// Watches the character, result and register channels of the NMEA line
// checker, keeps its own copy of the line state, predicts the verdict of
// every line and compares each result field with the oldest prediction.
// ---------------------------------------------------------------------------
module nsc_line_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  nsc_pkg::char_type     req_char_code,
   input  logic                  req_line_end,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  nsc_pkg::verdict_type  rsp_verdict,
   input  nsc_pkg::kind_type     rsp_sentence_kind,
   input  nsc_pkg::char_type     rsp_talker_first,
   input  nsc_pkg::char_type     rsp_talker_second,
   input  nsc_pkg::char_type     rsp_computed_sum,
   input  nsc_pkg::char_type     rsp_received_sum,
   input  logic                  rsp_received_too_big,
   input  nsc_pkg::len_type      rsp_line_length,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  nsc_pkg::csr_idx_type  csr_index,
   input  nsc_pkg::char_type     csr_data,
   output int                    fail_count,
   output int                    pending,
   output int                    lines_checked,
   output logic [6:0]            verdicts_seen,
   output logic [14:0]           kinds_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   import nsc_pkg::*;

   typedef struct {
      verdict_type verdict;
      kind_type    kind;
      char_type    talker_first;
      char_type    talker_second;
      char_type    computed_sum;
      char_type    received_sum;
      logic        too_big;
      len_type     length;
   } line_verdict_type;

   line_verdict_type pending_verdicts[$];

   len_type  min_len;
   len_type  max_len;
   len_type  line_pos;
   char_type xor_acc;
   char_type xor_at_star;
   logic     star_found;
   char_type hex_acc;
   logic     hex_big;
   logic     hex_done;
   char_type lead_char;
   char_type header [HEADER_DEPTH];

   int         errors = 0;
   int         checked = 0;
   logic [6:0]  seen_verdicts = '0;
   logic [14:0] seen_kinds = '0;

   function automatic void clear_line_state();
      line_pos    = '0;
      xor_acc     = '0;
      xor_at_star = '0;
      star_found  = 1'b0;
      hex_acc     = '0;
      hex_big     = 1'b0;
      hex_done    = 1'b0;
      lead_char   = '0;
      foreach (header[i]) header[i] = '0;
   endfunction

   // value of a hex digit, -1 for anything else
   function automatic int hex_value_of(input char_type c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   function automatic kind_type sentence_kind_of();
      for (int k = 0; k < KIND_COUNT; k++) begin
         if ({header[2], header[3], header[4]} == KIND_CODES[k]) return kind_type'(k + 1);
      end
      return KIND_UNKNOWN;
   endfunction

   function automatic void scan_char(input char_type c, input logic last);
      line_verdict_type v;
      int               d;
      if (line_pos == 0) begin
         lead_char = c;
      end else begin
         if (line_pos <= HEADER_DEPTH) header[line_pos - 1] = c;
         if (c == CHAR_STAR) begin
            // a later star restarts the checksum text
            xor_at_star = xor_acc;
            star_found  = 1'b1;
            hex_acc     = '0;
            hex_big     = 1'b0;
            hex_done    = 1'b0;
         end else if (star_found && !hex_done) begin
            d = hex_value_of(c);
            if (d < 0) begin
               hex_done = 1'b1;
            end else begin
               if (hex_acc >= 16) hex_big = 1'b1;
               hex_acc = {hex_acc[3:0], 4'(d)};
            end
         end
         xor_acc ^= c;
      end
      if (line_pos != LEN_MAX) line_pos++;
      if (!last) return;

      v.length        = line_pos;
      v.kind          = sentence_kind_of();
      v.talker_first  = header[0];
      v.talker_second = header[1];
      v.computed_sum  = star_found ? xor_at_star : '0;
      v.received_sum  = star_found ? hex_acc : '0;
      v.too_big       = star_found && hex_big;
      if (v.length < min_len || v.length > max_len) begin
         v.verdict = VERDICT_BAD_LENGTH;
      end else if (lead_char != CHAR_DOLLAR && lead_char != CHAR_BANG) begin
         v.verdict = VERDICT_BAD_START;
      end else if (!star_found) begin
         v.verdict = VERDICT_NO_STAR;
      end else if (v.too_big || v.received_sum != v.computed_sum) begin
         v.verdict = VERDICT_MISMATCH;
      end else if (lead_char == CHAR_BANG) begin
         v.verdict = VERDICT_OK_BANG;
      end else if (v.kind == KIND_UNKNOWN) begin
         v.verdict = VERDICT_UNKNOWN;
      end else begin
         v.verdict = VERDICT_OK_DOLLAR;
      end
      pending_verdicts.push_back(v);
      clear_line_state();
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   function automatic void check_verdict();
      line_verdict_type v;
      if (pending_verdicts.size() == 0) begin
         $error("result transaction with no line waiting: verdict %0d, length %0d",
                rsp_verdict, rsp_line_length);
         errors++;
         return;
      end
      v = pending_verdicts.pop_front();
      check_field("verdict", 8'(v.verdict), 8'(rsp_verdict));
      check_field("sentence_kind", 8'(v.kind), 8'(rsp_sentence_kind));
      check_field("talker_first", v.talker_first, rsp_talker_first);
      check_field("talker_second", v.talker_second, rsp_talker_second);
      check_field("computed_sum", v.computed_sum, rsp_computed_sum);
      check_field("received_sum", v.received_sum, rsp_received_sum);
      check_field("received_too_big", 8'(v.too_big), 8'(rsp_received_too_big));
      check_field("line_length", v.length, rsp_line_length);
      checked++;
      seen_verdicts[v.verdict] = 1'b1;
      seen_kinds[v.kind] = 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         min_len = MIN_LENGTH_RESET;
         max_len = MAX_LENGTH_RESET;
         clear_line_state();
         pending_verdicts.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_verdict();
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MIN_LENGTH) min_len = csr_data;
            else if (csr_index == CSR_MAX_LENGTH) max_len = csr_data;
         end
         if (req_valid && !req_stall) scan_char(req_char_code, req_line_end);
      end
      fail_count    <= errors;
      pending       <= pending_verdicts.size();
      lines_checked <= checked;
      verdicts_seen <= seen_verdicts;
      kinds_seen    <= seen_kinds;
   end

endmodule

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Feeds NMEA lines one character per transaction into the line checker:
// a directed set of corner lines under several length limits, then random
// well-formed, damaged and noise lines with sender gaps and result stalls.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import nsc_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 6;
   localparam int PHASE_CHARS  = 25;
   localparam int PHASE_LINES  = 2;

   localparam char_type CHAR_CR    = 8'h0d;
   localparam char_type CHAR_LF    = 8'h0a;
   localparam char_type CHAR_COMMA = 8'h2c;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   char_type    req_char_code = '0;
   logic        req_line_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   verdict_type rsp_verdict;
   kind_type    rsp_sentence_kind;
   char_type    rsp_talker_first;
   char_type    rsp_talker_second;
   char_type    rsp_computed_sum;
   char_type    rsp_received_sum;
   logic        rsp_received_too_big;
   len_type     rsp_line_length;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   csr_idx_type csr_index = CSR_MIN_LENGTH;
   char_type    csr_data = '0;

   int          fail_count;
   int          pending;
   int          lines_checked;
   logic [6:0]  verdicts_seen;
   logic [14:0] kinds_seen;

   int       sender_idle_pct = 0;
   int       stall_pct = 0;
   int       hold_token = 0;
   int       chars_sent = 0;
   int       quiet_cycles = 0;
   char_type line_buf[$];

   nmea_sentence_checker_unit u_top (.*);

   nsc_line_checker u_line_check (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side: random stalls, or a long hold-off when asked for
   int hold_seen = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_char(input char_type c, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      req_line_end  <= last;
      do @(posedge clock); while (req_stall);
      chars_sent++;
   endtask

   task automatic send_line();
      foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      // the last character may still sit in the input register
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input char_type value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_limits(input char_type shortest, input char_type longest);
      wait_drained();
      write_reg(CSR_MIN_LENGTH, shortest);
      write_reg(CSR_MAX_LENGTH, longest);
   endtask

   function automatic char_type hex_char(input logic [3:0] n, input bit lower);
      if (n < 10) return char_type'("0" + n);
      return char_type'((lower ? "a" : "A") + n - 10);
   endfunction

   task automatic text_line(input string s);
      line_buf.delete();
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   task automatic add_rand_text(input int n);
      char_type c;
      repeat (n) begin
         c = char_type'($urandom_range(126, 32));
         if (c == CHAR_STAR) c = CHAR_COMMA;
         line_buf.push_back(c);
      end
   endtask

   // star plus two hex digits of the span so far, xor'ed with flip
   task automatic add_sum(input char_type flip, input bit lower);
      char_type span;
      span = flip;
      for (int i = 1; i < line_buf.size(); i++) span ^= line_buf[i];
      line_buf.push_back(CHAR_STAR);
      line_buf.push_back(hex_char(span[7:4], lower));
      line_buf.push_back(hex_char(span[3:0], lower));
   endtask

   task automatic make_line();
      int              form;
      logic [23:0]     code;
      char_type        flip;
      form = $urandom_range(99);
      line_buf.delete();
      if (form >= 88) begin
         repeat ($urandom_range(20, 1)) line_buf.push_back(char_type'($urandom_range(255)));
         return;
      end
      line_buf.push_back(($urandom_range(3) == 0) ? CHAR_BANG : CHAR_DOLLAR);
      if (form >= 76 && form < 78) line_buf[0] = CHAR_STAR;
      else if (form >= 72 && form < 76) line_buf[0] = char_type'($urandom_range(255));
      if (form >= 78 && form < 81) begin
         // empty checksum span
         line_buf.push_back(CHAR_STAR);
         if ($urandom_range(1)) add_text("00");
         add_rand_text($urandom_range(12));
         return;
      end
      repeat (2) line_buf.push_back(char_type'($urandom_range(int'("Z"), int'("A"))));
      if ($urandom_range(99) < 85) begin
         code = KIND_CODES[$urandom_range(KIND_COUNT - 1)];
      end else begin
         repeat (3) code = {code[15:0], char_type'($urandom_range(int'("Z"), int'("A")))};
      end
      line_buf.push_back(code[23:16]);
      line_buf.push_back(code[15:8]);
      line_buf.push_back(code[7:0]);
      repeat ($urandom_range(3)) begin
         line_buf.push_back(($urandom_range(19) == 0) ? CHAR_STAR : CHAR_COMMA);
         add_rand_text($urandom_range(4));
      end
      if ($urandom_range(99) == 0) begin
         line_buf.push_back(CHAR_COMMA);
         add_rand_text($urandom_range(250, 150));
      end
      if (form >= 81 && form < 84) return;
      if (form >= 84) begin
         add_sum('0, 1'($urandom_range(1)));
         if ($urandom_range(1)) begin
            // leading digit pushes the value past a byte
            line_buf.insert(line_buf.size() - 2, hex_char(4'($urandom_range(15, 1)), 1'b0));
         end else begin
            line_buf.insert(line_buf.size() - 1, "G");
         end
         return;
      end
      flip = ($urandom_range(9) == 0) ? char_type'($urandom_range(255, 1)) : '0;
      add_sum(flip, 1'($urandom_range(1)));
      if ($urandom_range(3) == 0) begin
         line_buf.push_back(CHAR_CR);
         line_buf.push_back(CHAR_LF);
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_in);
      int first_char;
      int lines;
      sender_idle_pct = idle_pct;
      stall_pct <= stall_in;
      first_char = chars_sent;
      lines = 0;
      while (chars_sent - first_char < PHASE_CHARS || lines < PHASE_LINES) begin
         make_line();
         send_line();
         lines++;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      text_line("$GPRMC,123519,A");   add_sum('0, 1'b0); send_line();
      text_line("!AIVDM,1,1,,A,1");   add_sum('0, 1'b1); send_line();
      text_line("#GPMWV,12.5,R");     add_sum('0, 1'b0); send_line();
      // star as the start character
      text_line("*GPMWV,12.5,R");     add_sum('0, 1'b0); send_line();
      text_line("$GPMWV,12.5,R,N");   send_line();
      text_line("$GPHDM,10.0,M");     add_sum(8'h01, 1'b0); send_line();
      text_line("$GPHDM,10.0,M");     add_sum('0, 1'b0);
      line_buf.insert(line_buf.size() - 2, "1");
      send_line();
      text_line("$GPXYZ,1,2");        add_sum('0, 1'b0); send_line();
      text_line("$IIMWV,1,2");        add_sum('0, 1'b1);
      line_buf.push_back(CHAR_CR);
      line_buf.push_back(CHAR_LF);
      send_line();
      text_line("$IIMWV,1,2,3*");     send_line();
      text_line("$GP*MWV,1");         add_sum('0, 1'b0); send_line();
      text_line("$GPROT,");
      line_buf.push_back(8'h00);
      add_text(",A");                 add_sum('0, 1'b0); send_line();
      text_line("$*00,,,,,,");        send_line();
      text_line("!*FF");              send_line();

      set_limits(8'd0, 8'd255);
      text_line("$");                 send_line();
      text_line("$G");                send_line();
      text_line("$*");                send_line();
      line_buf.delete();
      repeat (6) line_buf.push_back(8'hff);
      line_buf.push_back(8'h00);
      send_line();

      // saturating length counter
      set_limits(8'd255, 8'd255);
      text_line("$GPMWV,");           add_rand_text(250); add_sum('0, 1'b0); send_line();
      set_limits(8'd0, 8'd0);
      text_line("!");                 send_line();

      set_limits(MIN_LENGTH_RESET, MAX_LENGTH_RESET);
      run_phase(0, 0);
      // hold results back while lines keep coming
      hold_token <= hold_token + 1;
      repeat (4) begin
         make_line();
         send_line();
      end

      set_limits(8'd0, 8'd255);
      run_phase(63, 0);
      set_limits(8'd12, 8'd24);
      run_phase(0, 63);
      set_limits(8'd6, 8'd40);
      run_phase(34, 34);
      wait_drained();

      $display("covered %0d characters and %0d line verdicts under six length windows",
               chars_sent, lines_checked);
      $display("verdict codes seen %b, sentence kinds seen %b", verdicts_seen, kinds_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
